// ===== src/dnp_pkg.sv =====
`timescale 1ns / 1ps

package dnp_pkg;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_IDENT,
      ST_DONE
   } state_type;

endpackage

// ===== src/dnp_ram.sv =====
`timescale 1ns / 1ps

module dnp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ===== src/degree_weighted_node_picker_core.sv =====
`timescale 1ns / 1ps

// Degree-weighted node picker. Clear and append finish in the idle state. A query runs two
// binary searches side by side over the prefix-sum memory, each step issuing the address
// and then comparing on the registered read data. A query moves through multiply, search
// read and compare, identifier read and done (an error goes from multiply straight to done),
// where it waits for the result register to drain. The read latency of the prefix memory
// sets the step time. One item is worked on at a time; appends are ignored once the table
// holds MAX_NODES nodes, and an empty table or zero total degree returns empty_error.
module degree_weighted_node_picker_core #(
   parameter int MAX_NODES = 1024,
   parameter int RAND_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_node_ident,
   input  logic [15:0] req_node_degree,
   input  logic [15:0] req_rand_first,
   input  logic [15:0] req_rand_second,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_first_pick,
   output logic [31:0] rsp_second_pick,
   output logic        rsp_empty_error
);

   localparam int AW   = $clog2(MAX_NODES);
   localparam int CW   = $clog2(MAX_NODES + 1);
   localparam int PW   = AW + 16;
   localparam int GW   = PW + 16;
   localparam int SW   = PW + RAND_BITS;
   localparam int CMPW = (SW > GW) ? SW : GW;
   localparam logic [15:0] RMASK =
      (RAND_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << RAND_BITS) - 64'd1);

   dnp_pkg::state_type state_ff, state_in;

   logic [CW-1:0]   count_ff, count_in;
   logic [PW-1:0]   total_ff, total_in;
   logic [15:0]     rand_ff [2];
   logic [15:0]     rand_in [2];
   logic [GW-1:0]   goal_ff [2];
   logic [GW-1:0]   goal_in [2];
   logic [CW-1:0]   lo_ff [2];
   logic [CW-1:0]   lo_in [2];
   logic [CW-1:0]   hi_ff [2];
   logic [CW-1:0]   hi_in [2];
   logic            err_ff, err_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [31:0]     first_ff, first_in;
   logic [31:0]     second_ff, second_in;
   logic            rsp_err_ff, rsp_err_in;

   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [CW:0]     mid_sum [2];
   logic [CW-1:0]   mid_full [2];
   logic [AW-1:0]   mid [2];
   logic [CW-1:0]   lo_dec [2];
   logic [AW-1:0]   pick [2];
   logic [PW-1:0]   prefix_rd [2];
   logic [31:0]     ident_rd [2];
   logic [CMPW-1:0] scaled [2];
   logic            below [2];

   assign wr_addr = count_ff[AW-1:0];

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         mid_sum[i]  = {1'b0, lo_ff[i]} + {1'b0, hi_ff[i]};
         mid_full[i] = mid_sum[i][CW:1];
         mid[i]      = mid_full[i][AW-1:0];
         lo_dec[i]   = lo_ff[i] - CW'(1);
         pick[i]     = (lo_ff[i] == '0) ? '0 : lo_dec[i][AW-1:0];
         scaled[i]   = CMPW'(prefix_rd[i]) << RAND_BITS;
         below[i]    = scaled[i] < CMPW'(goal_ff[i]);
      end
   end

   dnp_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_prefix_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (total_ff),
      .rd_addr_a (mid[0]),
      .rd_data_a (prefix_rd[0]),
      .rd_addr_b (mid[1]),
      .rd_data_b (prefix_rd[1])
   );

   dnp_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_ident_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (req_node_ident),
      .rd_addr_a (pick[0]),
      .rd_data_a (ident_rd[0]),
      .rd_addr_b (pick[1]),
      .rd_data_b (ident_rd[1])
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      rand_in      = rand_ff;
      goal_in      = goal_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      first_in     = first_ff;
      second_in    = second_ff;
      rsp_err_in   = rsp_err_ff;
      wr_en        = 1'b0;

      case (state_ff)
         dnp_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  dnp_pkg::OP_CLEAR: begin
                     count_in = '0;
                     total_in = '0;
                  end
                  dnp_pkg::OP_APPEND: begin
                     if (count_ff < CW'(MAX_NODES)) begin
                        wr_en    = 1'b1;
                        total_in = total_ff + PW'(req_node_degree);
                        count_in = count_ff + CW'(1);
                     end
                  end
                  dnp_pkg::OP_QUERY: begin
                     rand_in[0] = req_rand_first & RMASK;
                     rand_in[1] = req_rand_second & RMASK;
                     state_in   = dnp_pkg::ST_MUL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         dnp_pkg::ST_MUL: begin
            for (int i = 0; i < 2; i++) begin
               goal_in[i] = GW'(rand_ff[i]) * GW'(total_ff);
               lo_in[i]   = '0;
               hi_in[i]   = count_ff;
            end
            if (count_ff == '0 || total_ff == '0) begin
               err_in   = 1'b1;
               state_in = dnp_pkg::ST_DONE;
            end else begin
               err_in   = 1'b0;
               state_in = dnp_pkg::ST_SRCH_RD;
            end
         end
         dnp_pkg::ST_SRCH_RD: begin
            state_in = dnp_pkg::ST_SRCH_CMP;
         end
         dnp_pkg::ST_SRCH_CMP: begin
            // lanes that have converged hold their bounds
            for (int i = 0; i < 2; i++) begin
               if (lo_ff[i] < hi_ff[i]) begin
                  if (below[i]) begin
                     lo_in[i] = mid_full[i] + CW'(1);
                  end else begin
                     hi_in[i] = mid_full[i];
                  end
               end
            end
            if (lo_in[0] >= hi_in[0] && lo_in[1] >= hi_in[1]) begin
               state_in = dnp_pkg::ST_IDENT;
            end else begin
               state_in = dnp_pkg::ST_SRCH_RD;
            end
         end
         dnp_pkg::ST_IDENT: begin
            state_in = dnp_pkg::ST_DONE;
         end
         dnp_pkg::ST_DONE: begin
            // wait for the result register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               first_in     = err_ff ? 32'd0 : ident_rd[0];
               second_in    = err_ff ? 32'd0 : ident_rd[1];
               rsp_err_in   = err_ff;
               state_in     = dnp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dnp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dnp_pkg::ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rand_ff    <= rand_in;
      goal_ff    <= goal_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      err_ff     <= err_in;
      first_ff   <= first_in;
      second_ff  <= second_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign req_ready       = (state_ff == dnp_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_first_pick  = first_ff;
   assign rsp_second_pick = second_ff;
   assign rsp_empty_error = rsp_err_ff;

endmodule

// ===== src/dnp_checker.sv =====
`timescale 1ns / 1ps

module dnp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_op,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_first_pick,
   input logic [31:0] rsp_second_pick,
   input logic        rsp_empty_error
);

   // a stalled result transfer holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_first_pick)
         && $stable(rsp_second_pick) && $stable(rsp_empty_error))
      else $error("result changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_error |-> rsp_first_pick == 32'd0 && rsp_second_pick == 32'd0)
      else $error("picks not zero on empty error");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == dnp_pkg::OP_QUERY |=> !req_ready)
      else $error("query did not occupy the block");

   a_reset_clean: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind degree_weighted_node_picker_core dnp_checker u_dnp_checker (.*);
